// ===== rtl/slle_pkg.sv =====
// ----------------------------------------------------------------------------
// slle_pkg
// Shared types and codes of the static linked list engine: request kinds,
// result status codes and the result item layout.
// ----------------------------------------------------------------------------
package slle_pkg;

   localparam int VALUE_W            = 32;
   localparam int REQ_W              = 2;
   localparam int STATUS_W           = 3;
   localparam int SLOT_OUT_W         = 4;
   localparam int DEFAULT_LIST_DEPTH = 16;
   localparam int MAX_RESULTS        = 16;
   localparam int RES_CNT_W          = $clog2(MAX_RESULTS + 1);

   // request kinds
   localparam logic [REQ_W-1:0] REQ_APPEND   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SEARCH   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TRAVERSE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TRAV_ITEM = 3'd5;

   typedef struct packed {
      logic                  last;
      logic [VALUE_W-1:0]    out_value;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

endpackage

// ===== rtl/slle_store.sv =====
// ----------------------------------------------------------------------------
// slle_store
// Slot storage: a value memory and a next-slot link memory, one write port
// each and a shared read address with registered read data.
// ----------------------------------------------------------------------------
module slle_store #(
   parameter int LIST_DEPTH = slle_pkg::DEFAULT_LIST_DEPTH,
   parameter int SLOT_W     = $clog2(LIST_DEPTH)
) (
   input  logic                         clock,
   input  logic                         val_we,
   input  logic [SLOT_W-1:0]            val_waddr,
   input  logic [slle_pkg::VALUE_W-1:0] val_wdata,
   input  logic                         lnk_we,
   input  logic [SLOT_W-1:0]            lnk_waddr,
   input  logic [SLOT_W-1:0]            lnk_wdata,
   input  logic [SLOT_W-1:0]            rd_addr,
   output logic [slle_pkg::VALUE_W-1:0] rd_value,
   output logic [SLOT_W-1:0]            rd_link
);
   import slle_pkg::*;

   logic [VALUE_W-1:0] value_mem [LIST_DEPTH];
   logic [SLOT_W-1:0]  link_mem  [LIST_DEPTH];

   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_waddr] <= val_wdata;
      end
      rd_value <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         link_mem[lnk_waddr] <= lnk_wdata;
      end
      rd_link <= link_mem[rd_addr];
   end

endmodule

// ===== rtl/slle_ctrl.sv =====
// ----------------------------------------------------------------------------
// slle_ctrl
// Sequencer of the list engine: list bookkeeping (count, head, tail), slot
// scans for search and traversal, and the result output register.
// ----------------------------------------------------------------------------
module slle_ctrl #(
   parameter int LIST_DEPTH = slle_pkg::DEFAULT_LIST_DEPTH,
   parameter int SLOT_W     = $clog2(LIST_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [slle_pkg::REQ_W-1:0]   req_kind,
   input  logic [slle_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output slle_pkg::rsp_type            rsp_item,
   output logic                         val_we,
   output logic [SLOT_W-1:0]            val_waddr,
   output logic [slle_pkg::VALUE_W-1:0] val_wdata,
   output logic                         lnk_we,
   output logic [SLOT_W-1:0]            lnk_waddr,
   output logic [SLOT_W-1:0]            lnk_wdata,
   output logic [SLOT_W-1:0]            rd_addr,
   input  logic [slle_pkg::VALUE_W-1:0] rd_value,
   input  logic [SLOT_W-1:0]            rd_link
);
   import slle_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > RES_CNT_W) ? CNT_W : RES_CNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_TRAV   = 2'd2;
   localparam logic [1:0] S_FINAL  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]    head_ff, head_in;
   logic [SLOT_W-1:0]    tail_ff, tail_in;
   logic [SLOT_W-1:0]    scan_ff;
   logic [VALUE_W-1:0]   key_ff, key_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [VALUE_W-1:0]   pend_value_ff, pend_value_in;
   rsp_type              fin_ff, fin_in;
   rsp_type              out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic                 out_free;
   logic                 match;
   logic                 emit_pend;
   logic                 scan_at_end;
   logic                 trav_last;
   logic                 cap_hit;
   logic                 out_load;

   function automatic logic [SLOT_OUT_W-1:0] slot4(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_OUT_W-1:0] e;
      e = {{SLOT_OUT_W{1'b0}}, s};
      return e[SLOT_OUT_W-1:0];
   endfunction

   assign out_free    = !out_valid_ff || rsp_ready;
   assign match       = (rd_value == key_ff);
   assign emit_pend   = match && pend_valid_ff;
   assign cap_hit     = (res_cnt_ff == RES_CNT_W'(MAX_RESULTS - 1));
   assign scan_at_end = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;
   assign trav_last   = ((CMP_W'(res_cnt_ff) + CMP_W'(1)) == CMP_W'(count_ff)) || cap_hit;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      key_in        = key_ff;
      res_cnt_in    = res_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_value_in = pend_value_ff;
      fin_in        = fin_ff;
      out_in        = out_ff;
      out_load      = 1'b0;
      val_we        = 1'b0;
      val_waddr     = count_ff[SLOT_W-1:0];
      val_wdata     = req_value;
      lnk_we        = 1'b0;
      lnk_waddr     = tail_ff;
      lnk_wdata     = count_ff[SLOT_W-1:0];
      rd_addr       = scan_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  REQ_APPEND: begin
                     state_in = S_FINAL;
                     if (count_ff == CNT_W'(LIST_DEPTH)) begin
                        fin_in = '{last: 1'b1, out_value: '0, slot_index: '0,
                                   status: ST_FULL};
                     end else begin
                        // the lowest free slot is always the fill count
                        val_we   = 1'b1;
                        lnk_we   = (count_ff != '0);
                        tail_in  = count_ff[SLOT_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                        if (count_ff == '0) begin
                           head_in = count_ff[SLOT_W-1:0];
                        end
                        fin_in = '{last: 1'b1, out_value: req_value,
                                   slot_index: slot4(count_ff[SLOT_W-1:0]),
                                   status: ST_APPENDED};
                     end
                  end
                  REQ_SEARCH: begin
                     key_in        = req_value;
                     res_cnt_in    = '0;
                     pend_valid_in = 1'b0;
                     rd_addr       = '0;
                     if (count_ff == '0) begin
                        state_in = S_FINAL;
                        fin_in   = '{last: 1'b1, out_value: '0, slot_index: '0,
                                     status: ST_NOT_FOUND};
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  REQ_TRAVERSE: begin
                     res_cnt_in = '0;
                     rd_addr    = head_ff;
                     if (count_ff == '0) begin
                        state_in = S_FINAL;
                        fin_in   = '{last: 1'b1, out_value: '0, slot_index: '0,
                                     status: ST_EMPTY};
                     end else begin
                        state_in = S_TRAV;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // a match is held back until the next match or the end of the scan so the final one can carry last
            if (!emit_pend || out_free) begin
               rd_addr = scan_ff + SLOT_W'(1);
               if (emit_pend) begin
                  out_load = 1'b1;
                  out_in   = '{last: 1'b0, out_value: pend_value_ff,
                               slot_index: slot4(pend_slot_ff), status: ST_FOUND};
               end
               if (match) begin
                  pend_valid_in = 1'b1;
                  pend_slot_in  = scan_ff;
                  pend_value_in = rd_value;
                  res_cnt_in    = res_cnt_ff + RES_CNT_W'(1);
               end
               if (scan_at_end || (match && cap_hit)) begin
                  state_in = S_FINAL;
                  if (match) begin
                     fin_in = '{last: 1'b1, out_value: rd_value,
                                slot_index: slot4(scan_ff), status: ST_FOUND};
                  end else if (pend_valid_ff) begin
                     fin_in = '{last: 1'b1, out_value: pend_value_ff,
                                slot_index: slot4(pend_slot_ff), status: ST_FOUND};
                  end else begin
                     fin_in = '{last: 1'b1, out_value: '0, slot_index: '0,
                                status: ST_NOT_FOUND};
                  end
               end
            end
         end
         S_TRAV: begin
            if (out_free) begin
               rd_addr    = rd_link;
               out_load   = 1'b1;
               out_in     = '{last: trav_last, out_value: rd_value,
                              slot_index: slot4(scan_ff), status: ST_TRAV_ITEM};
               res_cnt_in = res_cnt_ff + RES_CNT_W'(1);
               if (trav_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               out_load = 1'b1;
               out_in   = fin_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         res_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         res_cnt_ff    <= res_cnt_in;
      end
   end

   // head and tail are only read while the count is nonzero
   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      scan_ff       <= rd_addr;
      key_ff        <= key_in;
      pend_slot_ff  <= pend_slot_in;
      pend_value_ff <= pend_value_in;
      fin_ff        <= fin_in;
      out_ff        <= out_in;
   end

endmodule

// ===== rtl/static_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Array-based singly linked list of LIST_DEPTH slots with append, search
// and in-order traversal.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request item: tuser holds the request kind, tdata the
//   value. rsp_* returns result items: tuser holds the status, tdata the slot
//   index and stored value, tlast marks the final result of a request.
//   Requests are taken one at a time; req_tready is high while the sequencer
//   is idle, also while a finished result still waits in the output register.
//   Append: one result, through the final result and output registers.
//   Search: one pass over the occupied slots, one value memory read per cycle
//   unless a found result must wait on a full output register, up to 16 found
//   results. Traverse: follows the link memory one slot per cycle while the
//   output register is free, up to 16 results; each step waits on the link
//   read. An empty list or no match gives a single result. When the output
//   register is full and rsp_tready is low, the sequencer holds its position
//   and re-reads the current slot, nothing is dropped. Reset empties the list
//   by clearing the fill count; slot memories need no clearing.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
   parameter int LIST_DEPTH = slle_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // item_value
   input  logic [slle_pkg::REQ_W-1:0]      req_tuser,   // req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,   // slot_index, out_value, zero pad
   output logic [slle_pkg::STATUS_W-1:0]   rsp_tuser,   // status
   output logic                            rsp_tlast    // last
);
   import slle_pkg::*;

   localparam int SLOT_W = $clog2(LIST_DEPTH);

   logic                val_we;
   logic [SLOT_W-1:0]   val_waddr;
   logic [VALUE_W-1:0]  val_wdata;
   logic                lnk_we;
   logic [SLOT_W-1:0]   lnk_waddr;
   logic [SLOT_W-1:0]   lnk_wdata;
   logic [SLOT_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  rd_value;
   logic [SLOT_W-1:0]   rd_link;
   rsp_type             rsp_item;

   slle_store #(
      .LIST_DEPTH(LIST_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_store (
      .clock    (clock),
      .val_we   (val_we),
      .val_waddr(val_waddr),
      .val_wdata(val_wdata),
      .lnk_we   (lnk_we),
      .lnk_waddr(lnk_waddr),
      .lnk_wdata(lnk_wdata),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   slle_ctrl #(
      .LIST_DEPTH(LIST_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_kind (req_tuser),
      .req_value(req_tdata),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_item (rsp_item),
      .val_we   (val_we),
      .val_waddr(val_waddr),
      .val_wdata(val_wdata),
      .lnk_we   (lnk_we),
      .lnk_waddr(lnk_waddr),
      .lnk_wdata(lnk_wdata),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   assign rsp_tdata = {4'b0000, rsp_item.out_value, rsp_item.slot_index};
   assign rsp_tuser = rsp_item.status;
   assign rsp_tlast = rsp_item.last;

endmodule

// ===== tb/static_linked_list_engine_checker.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_checker
// Watches the request and result channels of the linked list engine. Each
// accepted request is run through a local copy of the slot array, links,
// free map, head, tail and fill count to get the result items it must cause.
// Each accepted result is checked field by field against the oldest one due.
// ----------------------------------------------------------------------------
module static_linked_list_engine_checker
   import slle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         req_tdata,   // item_value
   input  logic [REQ_W-1:0]    req_tuser,   // req_type
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [39:0]         rsp_tdata,   // slot_index, out_value, zero pad
   input  logic [STATUS_W-1:0] rsp_tuser,   // status
   input  logic                rsp_tlast,   // last
   output int                  mismatch_count,
   output int                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         DEPTH     = DEFAULT_LIST_DEPTH;
   localparam logic [4:0] NULL_LINK = 5'h1f;   // -1 in link width

   logic [VALUE_W-1:0] slot_val [DEPTH];
   logic [4:0]         slot_next [DEPTH];
   bit                 slot_free [DEPTH];
   logic [4:0]         head_ix;
   logic [4:0]         tail_ix;
   int                 fill_count;
   rsp_type            replies_due [$];

   function automatic rsp_type make_reply(input logic [STATUS_W-1:0] st, input int slot,
                                          input logic [VALUE_W-1:0] value);
      rsp_type r;
      r.status     = st;
      r.slot_index = slot[SLOT_OUT_W-1:0];
      r.out_value  = value;
      r.last       = 1'b0;
      return r;
   endfunction

   task automatic list_op(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value);
      rsp_type batch [$];
      int      pick;
      int      cur;
      int      seen;
      pick = -1;
      case (kind)
         REQ_APPEND: begin
            for (int i = 0; i < DEPTH; i++)
               if (slot_free[i] && pick < 0) pick = i;
            if (pick < 0) begin
               batch.push_back(make_reply(ST_FULL, 0, '0));
            end else begin
               slot_val[pick]  = value;
               slot_next[pick] = NULL_LINK;
               if (fill_count == 0 || tail_ix >= DEPTH) head_ix = 5'(pick);
               else slot_next[tail_ix] = 5'(pick);
               tail_ix         = 5'(pick);
               slot_free[pick] = 1'b0;
               fill_count++;
               batch.push_back(make_reply(ST_APPENDED, pick, value));
            end
         end
         REQ_SEARCH: begin
            // only occupied slots take part, ascending slot order
            for (int i = 0; i < DEPTH; i++)
               if (!slot_free[i] && slot_val[i] == value && batch.size() < MAX_RESULTS)
                  batch.push_back(make_reply(ST_FOUND, i, slot_val[i]));
            if (batch.size() == 0) batch.push_back(make_reply(ST_NOT_FOUND, 0, '0));
         end
         REQ_TRAVERSE: begin
            cur  = head_ix;
            seen = 0;
            while (cur < DEPTH && seen < fill_count && batch.size() < MAX_RESULTS) begin
               batch.push_back(make_reply(ST_TRAV_ITEM, cur, slot_val[cur]));
               seen++;
               cur = slot_next[cur];
            end
            if (batch.size() == 0) batch.push_back(make_reply(ST_EMPTY, 0, '0));
         end
         default: ;   // unused code, no item comes back
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) replies_due.push_back(batch[k]);
   endtask

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         replies_due.delete();
         foreach (slot_free[i]) begin
            slot_free[i] = 1'b1;
            slot_next[i] = NULL_LINK;
            slot_val[i]  = '0;
         end
         head_ix    = NULL_LINK;
         tail_ix    = NULL_LINK;
         fill_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: no item expected, actual status %0d slot %0d value %h last %b",
                        $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tlast);
               mismatch_count++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_tdata[3:0]));
               check_field("out_value", want.out_value, rsp_tdata[35:4]);
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) list_op(req_tuser, req_tdata);
      end
      outstanding <= replies_due.size();
   end

endmodule

// ===== tb/static_linked_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_test
// Drives appends, searches, traversals and unused request codes into the
// linked list engine with random gaps and result back-pressure, including one
// long hold-off, and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------
module static_linked_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import slle_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 260;
   localparam int CALM_ITEMS   = 60;
   localparam int HOLD_AT      = 80;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 40;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic [REQ_W-1:0]    req_tuser  = REQ_APPEND;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [39:0]         rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic                rsp_tlast;

   int mismatch_count;
   int outstanding;
   int items_sent   = 0;
   int stall_cycles = 0;
   bit calm         = 1'b0;
   bit held_long    = 1'b0;

   logic [31:0] value_pool [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   static_linked_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   static_linked_list_engine_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // valid stays high into the next item unless a gap is taken
   task automatic offer(input logic [REQ_W-1:0] kind, input logic [31:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value(input int pool_pct);
      if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   initial begin
      int roll;
      int counted;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list, then extremes and duplicates
      offer(REQ_TRAVERSE, 32'hdead_beef);
      offer(REQ_SEARCH, 32'h0000_0000);
      offer(REQ_UNUSED, 32'hffff_ffff);
      offer(REQ_APPEND, 32'h8000_0000);
      offer(REQ_APPEND, 32'h7fff_ffff);
      offer(REQ_APPEND, 32'h0000_0000);
      offer(REQ_APPEND, 32'hffff_ffff);
      offer(REQ_APPEND, 32'h7fff_ffff);
      offer(REQ_SEARCH, 32'h7fff_ffff);
      offer(REQ_SEARCH, 32'hffff_ffff);
      offer(REQ_SEARCH, 32'h8000_0000);
      offer(REQ_SEARCH, 32'h7fff_fffe);
      offer(REQ_SEARCH, 32'h0000_0001);
      offer(REQ_TRAVERSE, 32'h0000_0000);
      offer(REQ_UNUSED, 32'h0000_0000);
      // fill the remaining slots, then one append past full
      for (int k = 0; k < 11; k++) offer(REQ_APPEND, 32'h0000_0000);
      offer(REQ_APPEND, 32'h1234_5678);
      offer(REQ_SEARCH, 32'h0000_0000);
      offer(REQ_TRAVERSE, $urandom());

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            offer(REQ_UNUSED, $urandom());
         end else begin
            if (roll < 35) offer(REQ_APPEND, pick_value(50));
            else if (roll < 80) offer(REQ_SEARCH, pick_value(60));
            else offer(REQ_TRAVERSE, $urandom());
            counted++;
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // result side back-pressure, one long hold-off to back up the request side
   initial begin
      repeat (6) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held_long && items_sent >= HOLD_AT) begin
            held_long = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ===== static_linked_list_engine.f =====
rtl/slle_pkg.sv
rtl/slle_store.sv
rtl/slle_ctrl.sv
rtl/static_linked_list_engine.sv
tb/static_linked_list_engine_checker.sv
tb/static_linked_list_engine_test.sv
